>>> rtl/emsu_pkg.sv
package emsu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int DT_W      = 17;
  localparam int LIM_W     = 31;
  localparam int PROD_W    = W + DT_W;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;
  localparam int NUM_W     = W + LIM_W;
  localparam int Q_W       = LIM_W;
  localparam int AXES      = 3;

  localparam logic [W-1:0] LIFE_EXPIRED = W'(-(64'sd1 <<< FRAC_BITS));

  typedef struct packed {
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic signed [W-1:0] pos_z;
    logic signed [W-1:0] vel_x;
    logic signed [W-1:0] vel_y;
    logic signed [W-1:0] vel_z;
    logic signed [W-1:0] acc_x;
    logic signed [W-1:0] acc_y;
    logic signed [W-1:0] acc_z;
    logic [LIM_W-1:0]    speed_limit;
    logic signed [W-1:0] life_left;
    logic [DT_W-1:0]     time_step;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] new_pos_x;
    logic signed [W-1:0] new_pos_y;
    logic signed [W-1:0] new_pos_z;
    logic signed [W-1:0] new_vel_x;
    logic signed [W-1:0] new_vel_y;
    logic signed [W-1:0] new_vel_z;
    logic signed [W-1:0] new_life;
    logic                expired;
  } out_t;

  // carried alongside the square root and divider stages
  typedef struct packed {
    logic [AXES-1:0][W-1:0]     pos;
    logic [AXES-1:0][W-1:0]     vel;
    logic [AXES-1:0][NUM_W-1:0] num;
    logic                       clamp;
    logic [W-1:0]               life;
    logic                       expired;
    logic [DT_W-1:0]            dt;
  } side_t;

  function automatic logic [W-1:0] mag32(logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  function automatic logic [W-1:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[W-1:0];
  endfunction

  // base + sat(+-(pm >> FRAC_BITS)), saturated
  function automatic logic [W-1:0] add_dt(logic [W-1:0] base, logic [PROD_W-1:0] pm,
                                          logic neg);
    logic signed [63:0] mag_s;
    logic signed [63:0] inner;
    logic [W-1:0]       inner_sat;
    logic signed [63:0] sum;
    mag_s     = $signed(64'(pm >> FRAC_BITS));
    inner     = neg ? -mag_s : mag_s;
    inner_sat = sat32(inner);
    sum       = $signed({{(64-W){base[W-1]}}, base}) +
                $signed({{(64-W){inner_sat[W-1]}}, inner_sat});
    return sat32(sum);
  endfunction

endpackage

>>> rtl/emsu_sqrt.sv
module emsu_sqrt import emsu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SQ_W-1:0]   in_n,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  // one root bit per stage, two radicand bits consumed per stage
  logic [ROOT_W-1:0] vld_r;
  logic [SQ_W-1:0]   n_r    [ROOT_W];
  logic [ROOT_W+2:0] rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
    localparam int P = ROOT_W - 1 - k;
    logic              p_vld;
    logic [SQ_W-1:0]   p_n;
    logic [ROOT_W+2:0] p_rem;
    logic [ROOT_W-1:0] p_root;
    side_t             p_side;
    logic [ROOT_W+2:0] sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_n    = in_n;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_n    = n_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      sh    = {p_rem[ROOT_W:0], p_n[2*P+1 -: 2]};
      trial = {1'b0, p_root, 2'b01};
      if (sh >= trial) begin
        rem_nxt  = sh - trial;
        root_nxt = {p_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sh;
        root_nxt = {p_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= p_n;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

>>> rtl/emsu_div.sv
module emsu_div import emsu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [ROOT_W-1:0]         in_len,
  input  side_t                     in_side,
  output logic                      out_vld,
  output logic [AXES-1:0][Q_W-1:0]  out_q,
  output side_t                     out_side
);

  // restoring division, three lanes sharing one divisor, one quotient bit per stage
  logic [Q_W-1:0]                 vld_r;
  logic [ROOT_W-1:0]              len_r [Q_W];
  logic [AXES-1:0][ROOT_W-1:0]    rem_r [Q_W];
  logic [AXES-1:0][Q_W-1:0]       q_r   [Q_W];
  side_t                          side_r[Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    localparam int B = Q_W - 1 - k;
    logic                        p_vld;
    logic [ROOT_W-1:0]           p_len;
    logic [AXES-1:0][ROOT_W-1:0] p_rem;
    logic [AXES-1:0][Q_W-1:0]    p_q;
    side_t                       p_side;
    logic [AXES-1:0][ROOT_W-1:0] rem_nxt;
    logic [AXES-1:0][Q_W-1:0]    q_nxt;

    if (k == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_len  = in_len;
      assign p_side = in_side;
      assign p_q    = '0;
      for (genvar a = 0; a < AXES; a++) begin : g_init
        assign p_rem[a] = in_side.num[a][NUM_W-1 -: ROOT_W];
      end
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_len  = len_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_q    = q_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      logic [ROOT_W:0] t;
      q_nxt = p_q;
      for (int a = 0; a < AXES; a++) begin
        t = {p_rem[a], p_side.num[a][B]};
        if (t >= {1'b0, p_len}) begin
          t           = t - {1'b0, p_len};
          q_nxt[a][B] = 1'b1;
        end
        rem_nxt[a] = t[ROOT_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k]  <= p_len;
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[Q_W-1];
  assign out_q    = q_r[Q_W-1];
  assign out_side = side_r[Q_W-1];

endmodule

>>> rtl/entity_motion_step_unit.sv
// Entity motion step: one semi-implicit Euler update per item.
// Input channel in_valid / in_stall / in_data carries one entity (position,
// velocity, acceleration, speed limit, life, dt, all fixed point). Result
// channel out_valid / out_stall / out_data returns the updated position,
// clamped velocity, life and the expired flag, one result per item, in order.
// Throughput: one item per cycle while the skid register is empty. From
// acceptance to out_valid an item passes 4 front stages (dt product,
// velocity add, squares, sum and limit test), 32 square root stages (one
// root bit each), 31 divider stages (one quotient bit each), 3 back stages
// (clamp select, dt product, position add) and the output register.
// When the receiver stalls, the output register holds its item and one more
// item drops into a skid register; only then does in_stall rise and the
// whole pipeline freeze, losing nothing. in_stall comes from a register.
// Reset (synchronous, rst_n low) clears every valid bit; no item is in
// flight afterwards and in_stall is low.
module entity_motion_step_unit import emsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic  en;
  logic  skid_vld_r;
  out_t  skid_r;
  logic  out_vld_r;
  out_t  out_r;

  // advance the whole pipeline unless the skid register is occupied
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // ---------------- stage A: acceleration * dt ----------------
  logic                         va_r;
  logic [AXES-1:0][PROD_W-1:0]  pm_a_r;
  logic [AXES-1:0]              neg_a_r;
  logic [AXES-1:0][W-1:0]       vel_a_r, pos_a_r;
  logic [LIM_W-1:0]             lim_a_r;
  logic [W-1:0]                 life_a_r;
  logic [DT_W-1:0]              dt_a_r;
  logic [AXES-1:0][W-1:0]       acc_in;

  assign acc_in = {in_data.acc_z, in_data.acc_y, in_data.acc_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        pm_a_r[a]  <= PROD_W'(mag32(acc_in[a])) * PROD_W'(in_data.time_step);
        neg_a_r[a] <= acc_in[a][W-1];
      end
      vel_a_r  <= {in_data.vel_z, in_data.vel_y, in_data.vel_x};
      pos_a_r  <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
      lim_a_r  <= in_data.speed_limit;
      life_a_r <= in_data.life_left;
      dt_a_r   <= in_data.time_step;
    end
  end

  // ---------------- stage B: velocity add, life countdown ----------------
  logic                   vb_r;
  logic [AXES-1:0][W-1:0] vel_b_r, pos_b_r;
  logic [LIM_W-1:0]       lim_b_r;
  logic [W-1:0]           life_b_r;
  logic                   exp_b_r;
  logic [DT_W-1:0]        dt_b_r;
  logic [W-1:0]           life_nxt;
  logic                   exp_nxt;

  always_comb begin
    logic signed [W:0] left;
    left     = $signed({life_a_r[W-1], life_a_r}) - $signed({{(W+1-DT_W){1'b0}}, dt_a_r});
    life_nxt = life_a_r;
    exp_nxt  = 1'b0;
    if ($signed(life_a_r) > 0) begin
      if (left <= 0) begin
        life_nxt = LIFE_EXPIRED;
        exp_nxt  = 1'b1;
      end else begin
        life_nxt = left[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        vel_b_r[a] <= add_dt(vel_a_r[a], pm_a_r[a], neg_a_r[a]);
      end
      pos_b_r  <= pos_a_r;
      lim_b_r  <= lim_a_r;
      life_b_r <= life_nxt;
      exp_b_r  <= exp_nxt;
      dt_b_r   <= dt_a_r;
    end
  end

  // ---------------- stage C: squares and limit products ----------------
  logic                       vc_r;
  logic [AXES-1:0][SQ_W-1:0]  sq_c_r;
  logic [2*LIM_W-1:0]         lim2_c_r;
  logic [AXES-1:0][NUM_W-1:0] num_c_r;
  logic [AXES-1:0][W-1:0]     vel_c_r, pos_c_r;
  logic [W-1:0]               life_c_r;
  logic                       exp_c_r;
  logic [DT_W-1:0]            dt_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        sq_c_r[a]  <= SQ_W'(mag32(vel_b_r[a])) * SQ_W'(mag32(vel_b_r[a]));
        num_c_r[a] <= NUM_W'(mag32(vel_b_r[a])) * NUM_W'(lim_b_r);
      end
      lim2_c_r <= (2*LIM_W)'(lim_b_r) * (2*LIM_W)'(lim_b_r);
      vel_c_r  <= vel_b_r;
      pos_c_r  <= pos_b_r;
      life_c_r <= life_b_r;
      exp_c_r  <= exp_b_r;
      dt_c_r   <= dt_b_r;
    end
  end

  // ---------------- stage D: speed squared and limit test ----------------
  logic            vd_r;
  logic [SQ_W-1:0] sum_d_r;
  side_t           side_d_r;
  logic [SQ_W-1:0] sum_nxt;

  assign sum_nxt = sq_c_r[0] + sq_c_r[1] + sq_c_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_d_r          <= sum_nxt;
      side_d_r.pos     <= pos_c_r;
      side_d_r.vel     <= vel_c_r;
      side_d_r.num     <= num_c_r;
      side_d_r.clamp   <= sum_nxt > {{(SQ_W-2*LIM_W){1'b0}}, lim2_c_r};
      side_d_r.life    <= life_c_r;
      side_d_r.expired <= exp_c_r;
      side_d_r.dt      <= dt_c_r;
    end
  end

  // ---------------- square root and divider ----------------
  logic              vs;
  logic [ROOT_W-1:0] root_s;
  side_t             side_s;
  logic              vq;
  logic [AXES-1:0][Q_W-1:0] q_q;
  side_t             side_q;

  emsu_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vd_r),
    .in_n     (sum_d_r),
    .in_side  (side_d_r),
    .out_vld  (vs),
    .out_root (root_s),
    .out_side (side_s)
  );

  emsu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vs),
    .in_len   (root_s),
    .in_side  (side_s),
    .out_vld  (vq),
    .out_q    (q_q),
    .out_side (side_q)
  );

  // ---------------- stage E: select clamped velocity ----------------
  logic                   ve_r;
  logic [AXES-1:0][W-1:0] vel_e_r, pos_e_r;
  logic [W-1:0]           life_e_r;
  logic                   exp_e_r;
  logic [DT_W-1:0]        dt_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        if (side_q.clamp) begin
          vel_e_r[a] <= side_q.vel[a][W-1] ? -{1'b0, q_q[a]} : {1'b0, q_q[a]};
        end else begin
          vel_e_r[a] <= side_q.vel[a];
        end
      end
      pos_e_r  <= side_q.pos;
      life_e_r <= side_q.life;
      exp_e_r  <= side_q.expired;
      dt_e_r   <= side_q.dt;
    end
  end

  // ---------------- stage F: velocity * dt ----------------
  logic                        vf_r;
  logic [AXES-1:0][PROD_W-1:0] pm_f_r;
  logic [AXES-1:0][W-1:0]      vel_f_r, pos_f_r;
  logic [W-1:0]                life_f_r;
  logic                        exp_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        pm_f_r[a] <= PROD_W'(mag32(vel_e_r[a])) * PROD_W'(dt_e_r);
      end
      vel_f_r  <= vel_e_r;
      pos_f_r  <= pos_e_r;
      life_f_r <= life_e_r;
      exp_f_r  <= exp_e_r;
    end
  end

  // ---------------- stage G: position add ----------------
  logic vg_r;
  out_t res_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_g_r.new_pos_x <= add_dt(pos_f_r[0], pm_f_r[0], vel_f_r[0][W-1]);
      res_g_r.new_pos_y <= add_dt(pos_f_r[1], pm_f_r[1], vel_f_r[1][W-1]);
      res_g_r.new_pos_z <= add_dt(pos_f_r[2], pm_f_r[2], vel_f_r[2][W-1]);
      res_g_r.new_vel_x <= vel_f_r[0];
      res_g_r.new_vel_y <= vel_f_r[1];
      res_g_r.new_vel_z <= vel_f_r[2];
      res_g_r.new_life  <= life_f_r;
      res_g_r.expired   <= exp_f_r;
    end
  end

  // ---------------- output register and skid ----------------
  // drain the skid first; otherwise load the output or, if it is stalled, park in skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (!out_stall) begin
        skid_vld_r <= 1'b0;
      end
    end else if (out_vld_r && out_stall) begin
      skid_vld_r <= vg_r;
    end else begin
      out_vld_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (!out_stall) begin
        out_r <= skid_r;
      end
    end else if (out_vld_r && out_stall) begin
      skid_r <= res_g_r;
    end else begin
      out_r <= res_g_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

>>> rtl/emsu_checker.sv
module emsu_checker import emsu_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  // input backpressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

  // expiry always reports life of minus one
  a_expired_life: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.expired |-> out_data.new_life == LIFE_EXPIRED)
    else $error("expired item with wrong life");

endmodule

bind entity_motion_step_unit emsu_checker u_emsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import emsu_pkg::*;

  // Allow margin for the drain at the end
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  out_t steps_due[$];
  int   err_count;
  int   items_sent;
  int   results_seen;
  int   expiries_seen;
  int   clamps_seen;
  int   cycle_count;
  bit   idle_enable;
  bit   hold_request;
  int   hold_len;

  entity_motion_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Motion predictor, in 64-bit signed arithmetic at Q16.16
  // ---------------------------------------------------------------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // x * dt, truncated toward zero, then saturated
  function automatic longint scale_by_dt(longint a, logic [DT_W-1:0] dt);
    logic [63:0] m;
    m = (a < 0) ? 64'(-a) : 64'(a);
    m = (m * 64'(dt)) >> FRAC_BITS;
    return clip32((a < 0) ? -$signed(m) : $signed(m));
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_t motion_step(in_t e, output bit clamped);
    longint      p[3];
    longint      v[3];
    longint      a[3];
    logic [63:0] mg[3];
    logic [63:0] sq;
    logic [63:0] lim;
    logic [63:0] len;
    logic [63:0] q;
    longint      life;
    out_t        r;
    p[0] = longint'(e.pos_x); p[1] = longint'(e.pos_y); p[2] = longint'(e.pos_z);
    v[0] = longint'(e.vel_x); v[1] = longint'(e.vel_y); v[2] = longint'(e.vel_z);
    a[0] = longint'(e.acc_x); a[1] = longint'(e.acc_y); a[2] = longint'(e.acc_z);
    lim = 64'(e.speed_limit);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = clip32(v[i] + scale_by_dt(a[i], e.time_step));
      mg[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sq = sq + mg[i] * mg[i];
    end
    clamped = (sq > lim * lim);
    if (clamped) begin
      len = floor_root(sq);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
        q = (mg[i] * lim) / len;
        v[i] = (v[i] < 0) ? -$signed(q) : $signed(q);
      end
    end
    for (int i = 0; i < 3; i++) p[i] = clip32(p[i] + scale_by_dt(v[i], e.time_step));
    life = longint'(e.life_left);
    r.expired = 1'b0;
    if (life > 0) begin
      life = life - longint'(e.time_step);
      if (life <= 0) begin
        life = -(64'sd1 << FRAC_BITS);
        r.expired = 1'b1;
      end
    end
    r.new_pos_x = p[0][31:0]; r.new_pos_y = p[1][31:0]; r.new_pos_z = p[2][31:0];
    r.new_vel_x = v[0][31:0]; r.new_vel_y = v[1][31:0]; r.new_vel_z = v[2][31:0];
    r.new_life  = life[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------
  // Sender: offer one item, queue its prediction once accepted
  // ---------------------------------------------------------------------
  task automatic send_item(in_t e);
    bit   c;
    out_t want;
    int   gap;
    // Insert a random burst of idle cycles before the item now and then
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = motion_step(e, c);
    if (c) clamps_seen++;
    steps_due.push_back(want);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (steps_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall in random bursts, or hold off for a long stretch
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_len  <= 0;
    end else if (hold_request) begin
      hold_len  <= 300;
      out_stall <= 1'b1;
    end else if (hold_len > 1) begin
      hold_len  <= hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_len == 1) begin
      hold_len  <= 0;
      out_stall <= 1'b0;
    end else if (idle_enable && !out_stall && $urandom_range(0, 5) == 0) begin
      hold_len  <= $urandom_range(1, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (steps_due.size() == 0) begin
        $display("unexpected result %0d", results_seen);
        err_count++;
      end else begin
        want = steps_due.pop_front();
        if (out_data.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", out_data.new_pos_x, want.new_pos_x);
        if (out_data.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", out_data.new_pos_y, want.new_pos_y);
        if (out_data.new_pos_z !== want.new_pos_z)
          report_mismatch("new_pos_z", out_data.new_pos_z, want.new_pos_z);
        if (out_data.new_vel_x !== want.new_vel_x)
          report_mismatch("new_vel_x", out_data.new_vel_x, want.new_vel_x);
        if (out_data.new_vel_y !== want.new_vel_y)
          report_mismatch("new_vel_y", out_data.new_vel_y, want.new_vel_y);
        if (out_data.new_vel_z !== want.new_vel_z)
          report_mismatch("new_vel_z", out_data.new_vel_z, want.new_vel_z);
        if (out_data.new_life !== want.new_life)
          report_mismatch("new_life", out_data.new_life, want.new_life);
        if (out_data.expired !== want.expired)
          report_mismatch("expired", 32'(out_data.expired), 32'(want.expired));
        if (want.expired) expiries_seen++;
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 40)) - 20) <<< 16;
      3: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t rand_entity();
    in_t e;
    e.pos_x = rand_word(); e.pos_y = rand_word(); e.pos_z = rand_word();
    e.vel_x = rand_word(); e.vel_y = rand_word(); e.vel_z = rand_word();
    e.acc_x = rand_word(); e.acc_y = rand_word(); e.acc_z = rand_word();
    case ($urandom_range(0, 4))
      0: e.speed_limit = '0;
      1: e.speed_limit = '1;
      2: e.speed_limit = LIM_W'($urandom_range(1, 1 << 22));
      default: e.speed_limit = LIM_W'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0: e.life_left = '0;
      1: e.life_left = LIFE_EXPIRED;
      2: e.life_left = 32'($urandom_range(1, 1 << 17));
      3: e.life_left = 32'h7fffffff;
      4: e.life_left = 32'(-signed'($urandom_range(1, 65536)));
      default: e.life_left = {1'b0, 31'($urandom())};
    endcase
    case ($urandom_range(0, 3))
      0: e.time_step = DT_W'($urandom_range(0, 1) << 16);
      1: e.time_step = DT_W'($urandom_range(0, 200));
      default: e.time_step = DT_W'($urandom_range(0, 65536));
    endcase
    return e;
  endfunction

  function automatic in_t still_entity();
    in_t e;
    e = '0;
    e.speed_limit = 31'h0010_0000;
    e.time_step   = DT_W'(1 << 16);
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_extremes();
    in_t e;
    e = still_entity();
    send_item(e);
    e = '1; e.time_step = DT_W'(1 << 16); send_item(e);
    e = '0;
    e.pos_x = 32'h7fffffff; e.pos_y = 32'h80000000; e.pos_z = 32'h7fffffff;
    e.vel_x = 32'h7fffffff; e.vel_y = 32'h80000000; e.vel_z = 32'h7fffffff;
    e.acc_x = 32'h7fffffff; e.acc_y = 32'h80000000; e.acc_z = 32'h80000000;
    e.speed_limit = '1; e.life_left = 32'h7fffffff; e.time_step = DT_W'(1 << 16);
    send_item(e);
    // saturation with the largest dt; the speed is clamped
    e.time_step = '1; send_item(e);
    // zero limit: moving entity stops, still one stays still
    e = still_entity(); e.vel_x = 32'h0003_0000; e.speed_limit = '0; send_item(e);
    e = still_entity(); e.speed_limit = '0; send_item(e);
    // speed exactly on the limit is not clamped; just above is
    e = still_entity(); e.vel_x = 32'h0003_0000; e.vel_y = 32'h0004_0000;
    e.speed_limit = 31'h0005_0000; send_item(e);
    e.vel_y = 32'h0004_0001; send_item(e);
    // tiny over-limit speed where the root is small
    e = still_entity(); e.vel_z = 32'hffff_ffff; e.speed_limit = '0; send_item(e);
    // life: counts down, hits zero exactly, goes below, never expires, expired, negative
    e = still_entity(); e.life_left = 32'h0002_0000; send_item(e);
    e.life_left = 32'h0001_0000; send_item(e);
    e.life_left = 32'h0000_0001; send_item(e);
    e.life_left = '0; send_item(e);
    e.life_left = LIFE_EXPIRED; send_item(e);
    e.life_left = 32'hffff_ffff; send_item(e);
    // zero time step
    e = still_entity(); e.vel_x = 32'h0001_0000; e.acc_y = 32'h7fff_0000;
    e.life_left = 32'h0000_0010; e.time_step = '0; send_item(e);
    wait_drained();
  endtask

  task automatic test_random_stream(int n);
    for (int i = 0; i < n; i++) send_item(rand_entity());
  endtask

  // Hold the receiver off while the sender keeps offering, so the block fills
  task automatic test_backpressure();
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    test_random_stream(120);
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    err_count    = 0;
    items_sent   = 0;
    results_seen = 0;
    expiries_seen = 0;
    clamps_seen  = 0;
    cycle_count  = 0;
    idle_enable  = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    idle_enable = 1'b1;
    test_random_stream(200);
    // sender pause until everything is back
    wait_drained();
    test_backpressure();
    idle_enable = 1'b0;
    test_random_stream(200);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d results, %0d speed clamps, %0d expiries",
             items_sent, results_seen, clamps_seen, expiries_seen);
    if (steps_due.size() != 0) begin
      $display("%0d results never arrived", steps_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/emsu_pkg.sv
rtl/emsu_sqrt.sv
rtl/emsu_div.sv
rtl/entity_motion_step_unit.sv
rtl/emsu_checker.sv
tb/sv/tb.sv
